>>> rtl/ffud_pkg.sv
// Package for the form field URL decoder: word types, queue command type,
// character constants and hex helpers. No dependencies.
`default_nettype none
package ffud_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       field_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } out_word_t;

    localparam int MAX_BYTES = 4;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // One accepted input word turned into up to four output bytes.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } cmd_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [4:0] HEX_BASE = 5'd16;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = HEX_BASE;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            d = {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return d;
    endfunction

    function automatic logic [7:0] plus_to_space(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/form_field_url_decoder_unit.sv
// Top level of the form field URL decoder: front end, command queue, back end.
// Depends on ffud_pkg, ffud_front, ffud_queue, ffud_back.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------
//   in       | in_valid / in_stall   | in_word_t  {in_byte, field_end}
//   out      | out_valid / out_stall | out_word_t {out_byte, has_byte, out_last}
//
// An input word yields zero to four output words, sent one per cycle by
// the back end while out_stall is low. The four-entry command queue
// and the output register set the rate: one word in per cycle while the
// queue has room. in_stall rises only when the queue is full. Reset
// clears the escape state, the queue and the output valid flag.
`default_nettype none
module form_field_url_decoder_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ffud_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ffud_pkg::out_word_t      out_data
);

    ffud_pkg::cmd_t wr_cmd, rd_cmd;
    logic           push, pop, empty, full, accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    ffud_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .word     (in_data),
        .cmd      (wr_cmd),
        .cmd_push (push)
    );

    ffud_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .empty  (empty),
        .full   (full)
    );

    ffud_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (rd_cmd),
        .cmd_empty (empty),
        .cmd_pop   (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

>>> rtl/ffud_front.sv
// Front end: accepts input words, tracks escape state, builds byte commands.
// Depends on ffud_pkg.
`default_nettype none
module ffud_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire ffud_pkg::in_word_t word,
    output ffud_pkg::cmd_t         cmd,
    output logic                   cmd_push
);

    typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_FIRST} phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] fhc_reg, fhc_next;
    logic       term_reg, term_next;

    logic       dv_en;
    logic [7:0] dv;
    logic       lt;
    logic [4:0] d1, d2, dn;
    logic [7:0] c2;
    logic       term_dv;

    always_comb
    begin
        phase_next = phase_reg;
        fhc_next   = fhc_reg;
        term_next  = term_reg;
        dv_en      = 1'b0;
        dv         = 8'h00;
        lt         = 1'b0;
        c2         = ffud_pkg::plus_to_space(word.in_byte);
        d1         = ffud_pkg::hex_digit(fhc_reg);
        d2         = ffud_pkg::hex_digit(c2);
        dn         = ffud_pkg::hex_digit(c2);
        if (!term_reg)
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (word.in_byte == 8'h00)
                    begin
                        phase_next = PH_IDLE;
                        term_next  = 1'b1;
                    end
                    else
                    begin
                        fhc_next   = c2;
                        phase_next = PH_FIRST;
                        if (word.field_end)
                        begin
                            dv_en = 1'b1;
                            dv    = dn[4] ? 8'h00 : {4'h0, dn[3:0]};
                        end
                    end
                end
                PH_FIRST:
                begin
                    phase_next = PH_IDLE;
                    if (word.in_byte == 8'h00)
                    begin
                        dv_en     = 1'b1;
                        dv        = d1[4] ? 8'h00 : {4'h0, d1[3:0]};
                        term_next = 1'b1;
                    end
                    else if (fhc_reg == ffud_pkg::CH_3 && c2 == ffud_pkg::CH_UC)
                    begin
                        lt = 1'b1;
                    end
                    else
                    begin
                        dv_en = 1'b1;
                        if (d1[4])
                        begin
                            dv = 8'h00;
                        end
                        else if (d2[4])
                        begin
                            dv = {4'h0, d1[3:0]};
                        end
                        else
                        begin
                            dv = {d1[3:0], d2[3:0]};
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (word.in_byte == ffud_pkg::CH_PCT)
                    begin
                        phase_next = PH_PCT;
                    end
                    else if (word.in_byte == 8'h00)
                    begin
                        term_next = 1'b1;
                    end
                    else
                    begin
                        dv_en = 1'b1;
                        dv    = c2;
                    end
                end
            endcase
        end
        if (word.field_end)
        begin
            phase_next = PH_IDLE;
            fhc_next   = 8'h00;
            term_next  = 1'b0;
        end
    end

    always_comb
    begin
        cmd.bytes = '0;
        cmd.count = '0;
        cmd.last  = word.field_end;
        if (lt)
        begin
            cmd.bytes[0] = ffud_pkg::CH_AMP;
            cmd.bytes[1] = ffud_pkg::CH_L;
            cmd.bytes[2] = ffud_pkg::CH_T;
            cmd.bytes[3] = ffud_pkg::CH_SEMI;
            cmd.count    = ffud_pkg::CNT_W'(4);
        end
        else if (dv_en && dv == ffud_pkg::CH_QUOTE)
        begin
            cmd.bytes[0] = ffud_pkg::CH_BSL;
            cmd.bytes[1] = ffud_pkg::CH_QUOTE;
            cmd.count    = ffud_pkg::CNT_W'(2);
        end
        else if (dv_en && dv != 8'h00)
        begin
            cmd.bytes[0] = dv;
            cmd.count    = ffud_pkg::CNT_W'(1);
        end
        cmd_push = accept && (cmd.count != '0 || word.field_end);
    end

    // decoded zero from an escape also closes the field
    assign term_dv = dv_en && dv == 8'h00 && !word.field_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fhc_reg   <= 8'h00;
            term_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            fhc_reg   <= fhc_next;
            term_reg  <= term_next | term_dv;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ffud_queue.sv
// Short command queue between front and back end.
// Depends on ffud_pkg.
`default_nettype none
module ffud_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ffud_pkg::cmd_t wr_cmd,
    input  wire logic           pop,
    output ffud_pkg::cmd_t      rd_cmd,
    output logic                empty,
    output logic                full
);

    ffud_pkg::cmd_t               mem [ffud_pkg::QDEPTH];
    logic [ffud_pkg::QAW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [ffud_pkg::QCNT_W-1:0]  cnt_reg;
    logic                         do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == ffud_pkg::QCNT_W'(ffud_pkg::QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/ffud_back.sv
// Back end: walks the head command one byte per cycle into the output
// register while out_stall is low. Depends on ffud_pkg.
`default_nettype none
module ffud_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ffud_pkg::cmd_t cmd,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output ffud_pkg::out_word_t out_data
);

    logic [ffud_pkg::IDX_W-1:0] idx_reg;
    logic                       valid_reg;
    ffud_pkg::out_word_t        data_reg, data_next;
    logic                       load, at_end;

    assign load      = !cmd_empty && (!valid_reg || !out_stall);
    assign at_end    = (cmd.count == '0) ||
                       ({1'b0, idx_reg} + 1'b1 == ffud_pkg::CNT_W'(cmd.count));
    assign cmd_pop   = load && at_end;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.out_byte = (cmd.count == '0) ? 8'h00 : cmd.bytes[idx_reg];
        data_next.has_byte = (cmd.count != '0);
        data_next.out_last = cmd.last && at_end;
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? '0 : idx_reg + 1'b1;
            end else if (!out_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
